// File: rtl/p3l_pkg.sv
`default_nettype none
package p3l_pkg;

  localparam int TW = 34;
  localparam int CW = 26;
  localparam int LEN_W = 18;
  localparam int PW = TW + LEN_W;

  typedef logic signed [TW-1:0] trig_t;
  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [LEN_W-1:0] len_t;

  localparam trig_t CORDIC_X0 = 34'sd652032874;
  localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] COORD_MIN = -24'sh800000;

  localparam logic [1:0] MODE_TIP = 2'd0;
  localparam logic [1:0] MODE_LINKS = 2'd1;
  localparam logic [1:0] MODE_CENTER = 2'd2;
  localparam logic [1:0] MODE_GRIP = 2'd3;

  localparam logic [2:0] REG_L1 = 3'd0;
  localparam logic [2:0] REG_L2 = 3'd1;
  localparam logic [2:0] REG_L3 = 3'd2;
  localparam logic [2:0] REG_GLEN = 3'd3;
  localparam logic [2:0] REG_GOFF = 3'd4;
  localparam logic [2:0] REG_GWID = 3'd5;

  // Product steps of the merge stage, in issue order.
  localparam logic [3:0] K_X1 = 4'd0;
  localparam logic [3:0] K_Y1 = 4'd1;
  localparam logic [3:0] K_X2 = 4'd2;
  localparam logic [3:0] K_Y2 = 4'd3;
  localparam logic [3:0] K_X3 = 4'd4;
  localparam logic [3:0] K_Y3 = 4'd5;
  localparam logic [3:0] K_GX = 4'd6;
  localparam logic [3:0] K_GY = 4'd7;
  localparam logic [3:0] K_EX = 4'd8;
  localparam logic [3:0] K_EY = 4'd9;
  localparam logic [3:0] K_BLX = 4'd10;
  localparam logic [3:0] K_BLY = 4'd11;
  localparam logic [3:0] K_BRX = 4'd12;
  localparam logic [3:0] K_BRY = 4'd13;
  localparam logic [3:0] K_LAST = 4'd14;

  localparam logic [3:0] P_BASE = 4'd0;
  localparam logic [3:0] P_ELBOW1 = 4'd1;
  localparam logic [3:0] P_ELBOW2 = 4'd2;
  localparam logic [3:0] P_FLANGE = 4'd3;
  localparam logic [3:0] P_END = 4'd4;
  localparam logic [3:0] P_CENTER = 4'd5;
  localparam logic [3:0] P_BL = 4'd6;
  localparam logic [3:0] P_BR = 4'd7;
  localparam logic [3:0] P_BL_TIP = 4'd8;
  localparam logic [3:0] P_BR_TIP = 4'd9;

  typedef enum logic [1:0] {
    M_IDLE,
    M_TERM,
    M_EMIT
  } merge_state_t;

  typedef struct packed {
    trig_t c1;
    trig_t s1;
    trig_t c2;
    trig_t s2;
    trig_t c3;
    trig_t s3;
  } trig_set_t;

  typedef struct packed {
    logic [15:0] l1;
    logic [15:0] l2;
    logic [15:0] l3;
    logic [15:0] glen;
    logic [15:0] goff;
    logic [15:0] gwid;
  } cfg_set_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/p3l_cordic_lane.sv
`default_nettype none
module p3l_cordic_lane
  import p3l_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] phase,
  output logic             busy,
  output logic             done,
  output trig_t            cos_val,
  output trig_t            sin_val
);

  localparam int IW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;

  logic          run;
  logic [IW-1:0] cnt;
  trig_t         x, y, z;
  logic [1:0]    quad;
  logic [31:0]   phase_adj, resid;
  trig_t         dx, dy, x_next, y_next, z_next, ang;
  logic [4:0]    idx;

  assign phase_adj = phase + 32'h2000_0000;
  assign resid = phase - {phase_adj[31:30], 30'b0};
  assign idx = 5'(cnt);
  assign ang = TW'(atan_entry(idx));
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;

  always_comb begin
    if (!z[TW-1]) begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - ang;
    end else begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == IW'(TRIG_ITERATIONS - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_X0;
      y <= '0;
      z <= TW'($signed(resid));
      quad <= phase_adj[31:30];
    end else if (run) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

  // The quadrant is folded back exactly after the rotation.
  always_comb begin
    case (quad)
      2'd0: begin
        cos_val = x;
        sin_val = y;
      end
      2'd1: begin
        cos_val = -y;
        sin_val = x;
      end
      2'd2: begin
        cos_val = -x;
        sin_val = -y;
      end
      default: begin
        cos_val = y;
        sin_val = -x;
      end
    endcase
  end

  assign busy = run;

endmodule
`default_nettype wire

// File: rtl/p3l_merge.sv
`default_nettype none
module p3l_merge
  import p3l_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  output logic                       ready,
  input  wire trig_set_t             trig_in,
  input  wire logic [1:0]            mode_in,
  input  wire logic [ANGLE_BITS-1:0] head_in,
  input  wire cfg_set_t              cfg,
  output logic                       strobe,
  output logic [3:0]                 point_index,
  output logic signed [23:0]         x_position,
  output logic signed [23:0]         y_position,
  output logic [ANGLE_BITS-1:0]      heading,
  output logic                       last_point
);

  localparam int LW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
  localparam logic signed [PW-1:0] RND30 = PW'(64'd536870912);
  localparam logic signed [PW-1:0] RND31 = PW'(64'd1073741824);

  merge_state_t state, state_next;
  logic [3:0] k, e, e_last, sel, kp;
  trig_set_t ts;
  logic [1:0] mode;
  logic [ANGLE_BITS-1:0] head;
  logic emit;

  coord_t x1, y1, x2, y2, x3, y3, gx, gy, ex, ey, blx, bly, brx, bry;
  logic signed [PW-1:0] prod;
  logic sh31;
  len_t l1, l2, l3, gl, go, gw, gd, opl;
  trig_t opt;
  coord_t tval, px, py;

  function automatic len_t mask_len(input logic [15:0] v);
    return len_t'(v[LW-1:0]);
  endfunction

  function automatic logic signed [23:0] sat(input coord_t v);
    logic signed [23:0] r;
    if (v > coord_t'(COORD_MAX)) r = COORD_MAX;
    else if (v < coord_t'(COORD_MIN)) r = COORD_MIN;
    else r = v[23:0];
    return r;
  endfunction

  assign l1 = mask_len(cfg.l1);
  assign l2 = mask_len(cfg.l2);
  assign l3 = mask_len(cfg.l3);
  assign gl = mask_len(cfg.glen);
  assign go = mask_len(cfg.goff);
  assign gw = mask_len(cfg.gwid);
  assign gd = gl - go;
  assign kp = k - 4'd1;

  always_comb begin
    case (k)
      K_X1: begin opl = l1; opt = ts.c1; end
      K_Y1: begin opl = l1; opt = ts.s1; end
      K_X2: begin opl = l2; opt = ts.c2; end
      K_Y2: begin opl = l2; opt = ts.s2; end
      K_X3: begin opl = l3; opt = ts.c3; end
      K_Y3: begin opl = l3; opt = ts.s3; end
      K_GX: begin opl = gd; opt = ts.c3; end
      K_GY: begin opl = gd; opt = ts.s3; end
      K_EX: begin opl = gl; opt = ts.c3; end
      K_EY: begin opl = gl; opt = ts.s3; end
      K_BLX: begin opl = gw; opt = -ts.s3; end
      K_BLY: begin opl = gw; opt = ts.c3; end
      K_BRX: begin opl = gw; opt = ts.s3; end
      K_BRY: begin opl = gw; opt = -ts.c3; end
      default: begin opl = '0; opt = '0; end
    endcase
  end

  // The jaw terms round at half scale because the width is halved.
  assign tval = sh31 ? CW'((prod + RND31) >>> 31) : CW'((prod + RND30) >>> 30);

  always_comb begin
    case (mode)
      MODE_TIP, MODE_CENTER: e_last = P_BASE;
      MODE_LINKS: e_last = P_FLANGE;
      default: e_last = P_BR_TIP;
    endcase
  end

  always_comb begin
    case (mode)
      MODE_TIP: sel = P_FLANGE;
      MODE_CENTER: sel = P_CENTER;
      default: sel = e;
    endcase
  end

  always_comb begin
    case (sel)
      P_ELBOW1: begin px = x1; py = y1; end
      P_ELBOW2: begin px = x2; py = y2; end
      P_FLANGE: begin px = x3; py = y3; end
      P_END: begin px = x3 + ex; py = y3 + ey; end
      P_CENTER: begin px = gx; py = gy; end
      P_BL: begin px = blx; py = bly; end
      P_BR: begin px = brx; py = bry; end
      P_BL_TIP: begin px = blx + ex; py = bly + ey; end
      P_BR_TIP: begin px = brx + ex; py = bry + ey; end
      default: begin px = '0; py = '0; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE: if (load) state_next = M_TERM;
      M_TERM: if (k == K_LAST) state_next = M_EMIT;
      M_EMIT: if (e == e_last) state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_comb begin
    ready = (state == M_IDLE);
    emit = (state == M_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      k <= '0;
      e <= '0;
      strobe <= 1'b0;
      last_point <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= emit;
      last_point <= emit && (e == e_last);
      if (state == M_IDLE) begin
        k <= '0;
        e <= '0;
      end
      if (state == M_TERM) k <= k + 4'd1;
      if (emit) e <= e + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      ts <= trig_in;
      mode <= mode_in;
      head <= head_in;
    end
    if (state == M_TERM) begin
      prod <= PW'(opl) * PW'(opt);
      sh31 <= (k >= K_BLX);
      if (k != K_X1) begin
        case (kp)
          K_X1: x1 <= tval;
          K_Y1: y1 <= tval;
          K_X2: x2 <= x1 + tval;
          K_Y2: y2 <= y1 + tval;
          K_X3: x3 <= x2 + tval;
          K_Y3: y3 <= y2 + tval;
          K_GX: gx <= x3 + tval;
          K_GY: gy <= y3 + tval;
          K_EX: ex <= tval;
          K_EY: ey <= tval;
          K_BLX: blx <= x3 + tval;
          K_BLY: bly <= y3 + tval;
          K_BRX: brx <= x3 + tval;
          K_BRY: bry <= y3 + tval;
          default: ;
        endcase
      end
    end
    point_index <= e;
    x_position <= sat(px);
    y_position <= sat(py);
    heading <= head;
  end

endmodule
`default_nettype wire

// File: rtl/planar_three_link_forward_kinematics.sv
// Channel   Transfer condition        Signals
// input     start & !busy             mode, joint_one_angle .. joint_three_angle
// result    strobe (one cycle)        point_index, x/y_position, heading, last_point
// config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Three CORDIC lanes rotate the three cumulative angles at once, one step a
// cycle. A new input is taken only once the lanes have finished the rotation,
// raised done and handed the finished rotation to the merge.
// The merge stage forms its terms on a single length-by-trig multiplier and
// emits 1, 4 or 10 points on consecutive cycles, overlapping the next item's
// rotation. While the merge is busy with a run, a finished rotation waits in
// the lanes and holds off the next input.
// Reset is synchronous and restores the default link lengths.
// Results cannot be stalled; they are shown for exactly one cycle.
`default_nettype none
module planar_three_link_forward_kinematics
  import p3l_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int LENGTH_BITS = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            mode,
  input  wire logic [ANGLE_BITS-1:0] joint_one_angle,
  input  wire logic [ANGLE_BITS-1:0] joint_two_angle,
  input  wire logic [ANGLE_BITS-1:0] joint_three_angle,
  output logic                       strobe,
  output logic [3:0]                 point_index,
  output logic signed [23:0]         x_position,
  output logic signed [23:0]         y_position,
  output logic [ANGLE_BITS-1:0]      heading,
  output logic                       last_point,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  localparam int PAD = 32 - ANGLE_BITS;

  cfg_set_t cfg;
  logic [ANGLE_BITS-1:0] a12, hsum, pend_head;
  logic [1:0] pend_mode;
  logic accept, lane_full, merge_ready, merge_load;
  logic [2:0] lane_busy, lane_done;
  logic [31:0] ph1, ph2, ph3;
  trig_set_t ts;

  assign cfg_ready = 1'b1;
  assign a12 = joint_one_angle + joint_two_angle;
  assign hsum = a12 + joint_three_angle;
  assign ph1 = {joint_one_angle, {PAD{1'b0}}};
  assign ph2 = {a12, {PAD{1'b0}}};
  assign ph3 = {hsum, {PAD{1'b0}}};

  assign busy = (|lane_busy) | (|lane_done) | lane_full;
  assign accept = start & ~busy;
  assign merge_load = lane_full & merge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{l1: 16'd4096, l2: 16'd4096, l3: 16'd4096,
               glen: 16'd0, goff: 16'd0, gwid: 16'd0};
      lane_full <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_L1: cfg.l1 <= cfg_data;
          REG_L2: cfg.l2 <= cfg_data;
          REG_L3: cfg.l3 <= cfg_data;
          REG_GLEN: cfg.glen <= cfg_data;
          REG_GOFF: cfg.goff <= cfg_data;
          REG_GWID: cfg.gwid <= cfg_data;
          default: ;
        endcase
      end
      if (lane_done[0]) lane_full <= 1'b1;
      else if (merge_load) lane_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_mode <= mode;
      pend_head <= hsum;
    end
  end

  p3l_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane1 (
    .clk(clk), .rst(rst), .start(accept), .phase(ph1),
    .busy(lane_busy[0]), .done(lane_done[0]), .cos_val(ts.c1), .sin_val(ts.s1)
  );

  p3l_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane2 (
    .clk(clk), .rst(rst), .start(accept), .phase(ph2),
    .busy(lane_busy[1]), .done(lane_done[1]), .cos_val(ts.c2), .sin_val(ts.s2)
  );

  p3l_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane3 (
    .clk(clk), .rst(rst), .start(accept), .phase(ph3),
    .busy(lane_busy[2]), .done(lane_done[2]), .cos_val(ts.c3), .sin_val(ts.s3)
  );

  p3l_merge #(.ANGLE_BITS(ANGLE_BITS), .LENGTH_BITS(LENGTH_BITS)) u_merge (
    .clk(clk), .rst(rst), .load(merge_load), .ready(merge_ready),
    .trig_in(ts), .mode_in(pend_mode), .head_in(pend_head), .cfg(cfg),
    .strobe(strobe), .point_index(point_index), .x_position(x_position),
    .y_position(y_position), .heading(heading), .last_point(last_point)
  );

endmodule
`default_nettype wire

// File: rtl/p3l_checker.sv
`default_nettype none
module p3l_checker #(
  parameter int ANGLE_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  strobe,
  input wire logic [3:0]            point_index,
  input wire logic [ANGLE_BITS-1:0] heading,
  input wire logic                  last_point
);

  // A run's points come out on consecutive cycles with rising indexes.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_point |=> strobe && point_index == $past(point_index) + 4'd1)
    else $error("run broken before its last point");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && point_index != 4'd0 |-> $past(strobe) && !$past(last_point))
    else $error("point without its predecessor");

  a_heading_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && point_index != 4'd0 |-> heading == $past(heading))
    else $error("heading changed within a run");

  a_last_with_strobe: assert property (@(posedge clk) disable iff (rst)
    last_point |-> strobe && point_index <= 4'd9)
    else $error("last point flag outside a result");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result right after reset");

endmodule

bind planar_three_link_forward_kinematics p3l_checker #(.ANGLE_BITS(ANGLE_BITS)) u_chk (
  .clk(clk), .rst(rst), .strobe(strobe), .point_index(point_index),
  .heading(heading), .last_point(last_point)
);
`default_nettype wire
